>>> rtl/iwps_pkg.sv
// Shared types, constants and lookup functions for the wheel prime sieve.
// Depends on nothing; the top level, iwps_ctrl and iwps_dpath import it.
`timescale 1ns / 1ps
`default_nettype none

package iwps_pkg;

  // Default number of entries in the multiple table.
  localparam int unsigned IWPS_TABLE_DEPTH = 1024;

  // Field and register widths.
  localparam int LIMIT_W = 26;
  localparam int BASE_W  = 27;
  localparam int MULT_W  = 32;
  localparam int STEP_W  = 16;
  localparam int SLOT_W  = 3;
  localparam int SEED_W  = 4;
  localparam int OFFS_W  = 5;
  localparam int SQ_W    = 2 * LIMIT_W;

  localparam logic [SEED_W-1:0]  SEED_COUNT   = 4'd10;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 26'd1000;
  localparam logic [BASE_W-1:0]  WHEEL_SPAN   = 27'd30;
  localparam logic [LIMIT_W-1:0] FIRST_TABLED = 26'd7;
  localparam logic [LIMIT_W-1:0] LOWEST_PRIME = 26'd2;
  localparam logic [MULT_W-1:0]  MULT_SAT     = '1;
  localparam logic [SLOT_W-1:0]  LAST_SLOT    = 3'd7;

  // Fixed primes reported before the wheel walk starts.
  function automatic logic [LIMIT_W-1:0] seed_prime(input logic [SEED_W-1:0] idx);
    logic [LIMIT_W-1:0] val;
    case (idx)
      4'd0:    val = 26'd2;
      4'd1:    val = 26'd3;
      4'd2:    val = 26'd5;
      4'd3:    val = 26'd7;
      4'd4:    val = 26'd11;
      4'd5:    val = 26'd13;
      4'd6:    val = 26'd17;
      4'd7:    val = 26'd19;
      4'd8:    val = 26'd23;
      4'd9:    val = 26'd29;
      default: val = '0;
    endcase
    return val;
  endfunction

  // Residues mod 30 that are coprime to 2, 3 and 5.
  function automatic logic [OFFS_W-1:0] wheel_offset(input logic [SLOT_W-1:0] slot);
    logic [OFFS_W-1:0] val;
    case (slot)
      3'd0:    val = 5'd1;
      3'd1:    val = 5'd7;
      3'd2:    val = 5'd11;
      3'd3:    val = 5'd13;
      3'd4:    val = 5'd17;
      3'd5:    val = 5'd19;
      3'd6:    val = 5'd23;
      3'd7:    val = 5'd29;
      default: val = 5'd1;
    endcase
    return val;
  endfunction

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEED,
    S_CAND,
    S_READ,
    S_CHECK,
    S_VERDICT,
    S_SQUARE,
    S_ENTER,
    S_EMIT
  } iwps_state_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic accept;      // take the request word (clears the walk on restart)
    logic finish;      // no prime left: raise finished, result 0 / done
    logic take_seed;   // report the next fixed prime
    logic take_cand;   // load the next wheel candidate and advance the wheel
    logic read;        // read the table entry at the scan index
    logic step;        // advance the working multiple once more
    logic retire;      // write the entry back and move to the next one
    logic take_prime;  // the candidate survived the scan
    logic square;      // register the square of the new prime
    logic enter;       // add the new prime to the table if it is 7 or more and there is room
    logic emit;        // move the result into the output register
  } iwps_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic               finished;
    logic               seed_pending;
    logic               seed_over;
    logic               cand_over;
    logic               table_empty;
    logic               more_steps;
    logic               last_entry;
    logic               composite;
    logic               out_free;
    logic [LIMIT_W-1:0] upper_limit;
  } iwps_status_t;

endpackage

`default_nettype wire

>>> rtl/iwps_in_if.sv
// Request channel of the wheel prime sieve: valid/ready plus the restart bit.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface iwps_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

>>> rtl/iwps_out_if.sv
// Result channel of the wheel prime sieve: valid/ready plus prime and done flag.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface iwps_out_if;
  logic        valid;
  logic        ready;
  logic [25:0] prime_value;
  logic        done_res;

  modport source (output valid, output prime_value, output done_res, input ready);
  modport sink   (input valid, input prime_value, input done_res, output ready);
endinterface

`default_nettype wire

>>> rtl/incremental_wheel_prime_sieve.sv
// Top level of the wheel prime sieve: sequencer, datapath and channel ports.
// Uses iwps_pkg, iwps_in_if, iwps_out_if, iwps_ctrl and iwps_dpath.
`timescale 1ns / 1ps
`default_nettype none

// Each request word returns exactly one result word: the next prime not above
// upper_limit, or 0 with done_res set once none remains; restart set in the
// request starts over at 2. The fixed primes 2 to 29 come first. After them
// every wheel candidate is checked against each entry in the multiple table,
// stepping an entry's multiple as often as needed, because the scan reads the
// table one entry at a time; the work per candidate grows with the number of
// entries, and a request covers every composite candidate skipped before its
// prime. Each new prime is then squared and entered in the table. The next
// request is taken while the previous result waits in the output register.
module incremental_wheel_prime_sieve
  import iwps_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = IWPS_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  iwps_in_if.sink            in_ch,
  iwps_out_if.source         out_ch
);

  iwps_cmd_t    cmd;
  iwps_status_t status;
  logic         in_ready;

  assign in_ch.ready = in_ready;

  // Sequencer.
  iwps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath with the multiple table and output register.
  iwps_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_restart      (in_ch.restart),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_prime_value (out_ch.prime_value),
    .out_done_res    (out_ch.done_res)
  );

  // A done word always carries a zero value.
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.done_res |-> out_ch.prime_value == '0)
    else $error("done word with a nonzero value");

  // A reported prime lies between 2 and the limit.
  a_prime_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.done_res |->
      (out_ch.prime_value >= LOWEST_PRIME) && (out_ch.prime_value <= status.upper_limit))
    else $error("reported prime outside 2 to the limit");

  // Only one request is in work at a time.
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request taken while another is in work");

endmodule

`default_nettype wire

>>> rtl/iwps_dpath.sv
// Datapath of the wheel prime sieve: walk registers, multiple table, squarer
// and the output register. Uses iwps_pkg; driven by iwps_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module iwps_dpath
  import iwps_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = IWPS_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  input  logic               in_restart,
  input  iwps_cmd_t          cmd,
  output iwps_status_t       status,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LIMIT_W-1:0] out_prime_value,
  output logic               out_done_res
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W = STEP_W + MULT_W;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

  // Walk state.
  logic [LIMIT_W-1:0] upper_limit;
  logic [BASE_W-1:0]  wheel_base;
  logic [SLOT_W-1:0]  wheel_slot;
  logic [SEED_W-1:0]  seed_index;
  logic [CNT_W-1:0]   entry_count;
  logic               finished;

  // Scan state.
  logic [LIMIT_W-1:0] cand;
  logic               composite;
  logic [IDX_W-1:0]   entry_idx;
  logic               first;
  logic [MULT_W-1:0]  mult_w;
  logic [STEP_W-1:0]  rd_step;
  logic [MULT_W-1:0]  rd_mult;
  logic [SQ_W-1:0]    square;
  logic [LIMIT_W-1:0] res_value;
  logic               res_done;

  // Multiple table: step in the upper bits, multiple in the lower bits.
  logic [ENT_W-1:0]   table_mem [TABLE_DEPTH];
  logic [ENT_W-1:0]   rd_data;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENT_W-1:0]   mem_wdata;

  logic               clear_walk;
  logic [LIMIT_W-1:0] seed_val;
  logic [BASE_W:0]    cand_sum;
  logic [MULT_W-1:0]  cand_ext;
  logic [MULT_W-1:0]  cur_mult;
  logic [MULT_W-1:0]  mult_sum;
  logic [MULT_W-1:0]  wb_mult;
  logic               mult_hit;
  logic               mult_eq;
  logic               enter_ok;
  logic [MULT_W-1:0]  sq_sat;
  logic [STEP_W-1:0]  step_new;

  assign clear_walk = cmd.accept & in_restart;
  assign seed_val   = seed_prime(seed_index);
  assign cand_sum   = {1'b0, wheel_base} + (BASE_W + 1)'(wheel_offset(wheel_slot));
  assign cand_ext   = MULT_W'(cand);
  assign rd_step    = rd_data[ENT_W-1:MULT_W];
  assign rd_mult    = rd_data[MULT_W-1:0];

  // Working multiple: fresh from the table on the first look, else the stepped copy.
  assign cur_mult = first ? rd_mult : mult_w;
  assign mult_sum = cur_mult + MULT_W'(rd_step);
  assign mult_hit = cur_mult <= cand_ext;
  assign mult_eq  = cur_mult == cand_ext;
  assign wb_mult  = mult_hit ? mult_sum : cur_mult;

  // New entry: step 2p kept to 16 bits, square saturated to 32 bits.
  assign enter_ok = (cand >= FIRST_TABLED) && (entry_count < DEPTH_CNT);
  assign sq_sat   = (|square[SQ_W-1:MULT_W]) ? MULT_SAT : square[MULT_W-1:0];
  assign step_new = {cand[STEP_W-2:0], 1'b0};

  // Table write port: scan write-back or a new entry.
  assign mem_we    = cmd.retire | (cmd.enter & enter_ok);
  assign mem_waddr = cmd.enter ? entry_count[IDX_W-1:0] : entry_idx;
  assign mem_wdata = cmd.enter ? {step_new, sq_sat} : {rd_step, wb_mult};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.read) begin
      rd_data <= table_mem[entry_idx];
    end
  end

  // Status toward the sequencer.
  always_comb begin
    status.finished     = finished;
    status.seed_pending = seed_index < SEED_COUNT;
    status.seed_over    = seed_val > upper_limit;
    status.cand_over    = cand_sum > (BASE_W + 1)'(upper_limit);
    status.table_empty  = entry_count == '0;
    status.more_steps   = mult_hit && (rd_step != '0) && (mult_sum <= cand_ext);
    status.last_entry   = CNT_W'(entry_idx) == (entry_count - ONE_CNT);
    status.composite    = composite;
    status.out_free     = !out_valid || out_ready;
    status.upper_limit  = upper_limit;
  end

  // Limit register and walk state.
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit <= LIMIT_RESET;
      wheel_base  <= WHEEL_SPAN;
      wheel_slot  <= '0;
      seed_index  <= '0;
      entry_count <= '0;
      finished    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        upper_limit <= cfg_wr_data;
      end
      if (clear_walk) begin
        wheel_base  <= WHEEL_SPAN;
        wheel_slot  <= '0;
        seed_index  <= '0;
        entry_count <= '0;
        finished    <= 1'b0;
      end
      if (cmd.finish) begin
        finished <= 1'b1;
      end
      if (cmd.take_seed) begin
        seed_index <= seed_index + SEED_W'(1);
      end
      if (cmd.take_cand) begin
        wheel_slot <= wheel_slot + SLOT_W'(1);
        if (wheel_slot == LAST_SLOT) begin
          wheel_base <= wheel_base + WHEEL_SPAN;
        end
      end
      if (cmd.enter && enter_ok) begin
        entry_count <= entry_count + ONE_CNT;
      end
    end
  end

  // Scan registers, squarer and pending result.
  always_ff @(posedge clk) begin
    if (cmd.take_seed) begin
      cand <= seed_val;
    end else if (cmd.take_cand) begin
      cand <= cand_sum[LIMIT_W-1:0];
    end
    if (cmd.take_cand) begin
      composite <= 1'b0;
      entry_idx <= '0;
    end else if (cmd.step || cmd.retire) begin
      composite <= composite | mult_eq;
      if (cmd.retire) begin
        entry_idx <= entry_idx + IDX_W'(1);
      end
    end
    if (cmd.read) begin
      first <= 1'b1;
    end else if (cmd.step) begin
      first  <= 1'b0;
      mult_w <= mult_sum;
    end
    if (cmd.square) begin
      square <= SQ_W'(cand) * SQ_W'(cand);
    end
    if (cmd.finish) begin
      res_value <= '0;
      res_done  <= 1'b1;
    end else if (cmd.take_seed) begin
      res_value <= seed_val;
      res_done  <= 1'b0;
    end else if (cmd.take_prime) begin
      res_value <= cand;
      res_done  <= 1'b0;
    end
  end

  // Output register: holds one word until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_prime_value <= res_value;
      out_done_res    <= res_done;
    end
  end

endmodule

`default_nettype wire

>>> rtl/iwps_ctrl.sv
// Sequencer of the wheel prime sieve: walks seeds, candidates and table entries.
// Uses iwps_pkg; commands iwps_dpath through iwps_cmd_t / iwps_status_t.
`timescale 1ns / 1ps
`default_nettype none

module iwps_ctrl
  import iwps_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  iwps_status_t status,
  output iwps_cmd_t    cmd
);

  iwps_state_t state;
  iwps_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (status.finished)          state_next = S_EMIT;
        else if (status.seed_pending) state_next = S_SEED;
        else                          state_next = S_CAND;
      end
      S_SEED: begin
        state_next = status.seed_over ? S_EMIT : S_SQUARE;
      end
      S_CAND: begin
        if (status.cand_over)        state_next = S_EMIT;
        else if (status.table_empty) state_next = S_VERDICT;
        else                         state_next = S_READ;
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!status.more_steps) begin
          state_next = status.last_entry ? S_VERDICT : S_READ;
        end
      end
      S_VERDICT: begin
        state_next = status.composite ? S_CAND : S_SQUARE;
      end
      S_SQUARE: begin
        state_next = S_ENTER;
      end
      S_ENTER: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Commands and request handshake.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_DISPATCH: begin
        cmd.finish = status.finished;
      end
      S_SEED: begin
        cmd.finish    = status.seed_over;
        cmd.take_seed = !status.seed_over;
      end
      S_CAND: begin
        cmd.finish    = status.cand_over;
        cmd.take_cand = !status.cand_over;
      end
      S_READ: begin
        cmd.read = 1'b1;
      end
      S_CHECK: begin
        cmd.step   = status.more_steps;
        cmd.retire = !status.more_steps;
      end
      S_VERDICT: begin
        cmd.take_prime = !status.composite;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
      end
      S_ENTER: begin
        cmd.enter = 1'b1;
      end
      S_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire
